### sv/assert_macros.svh
// Assertion helpers used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property sampled on the rising clock edge, off while reset is held.
`define PCU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("pcu assertion failed");

// Antecedent in one cycle implies the consequent in the next.
`define PCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcu assertion failed");

`endif

### sv/pcu_pkg.sv
`default_nettype none
package pcu_pkg;

	// Fixed point format of all operands and results.
	localparam int FRAC_BITS = 16;
	// Working magnitude width: any larger value saturates the result anyway.
	localparam int MAG_W = 63 - FRAC_BITS;
	localparam int HI_W = MAG_W - 32;
	localparam int NUM_W = MAG_W + 32;
	// Multiply-divide unit: two multiply stages, one set-up stage, one bit per stage.
	localparam int MD_LAT = MAG_W + 3;
	// Accept to result strobe.
	localparam int LATENCY = 3 * MD_LAT + 6;

	localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;
	localparam logic [31:0] TWO_Q = 32'd2 << FRAC_BITS;

	typedef enum logic [1:0] {
		MODE_LASSO = 2'd0,
		MODE_MCP   = 2'd1,
		MODE_SCAD  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REG_LAMBDA = 2'd0,
		REG_GAMMA  = 2'd1,
		REG_MODE   = 2'd2,
		REG_STDZ   = 2'd3
	} cfg_reg_t;

	// Item travelling down the pipeline alongside the arithmetic units.
	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic             s_neg;
		logic [31:0]      s_mag;
		logic             use_md;
		logic             fault;
	} item_t;

	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

endpackage
`default_nettype wire

### sv/pcu_front.sv
`default_nettype none
module pcu_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [31:0]   gradient,
	input  wire logic [31:0]   coef_old,
	input  wire logic [31:0]   col_scale,
	input  wire logic          stdz,
	output logic               out_valid,
	output pcu_pkg::item_t     out_item
);
	import pcu_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic        g_neg_s1, b_neg_s1, s_neg_s1;
	logic [31:0] g_mag_s1, b_mag_s1, s_mag_s1;
	logic        g_neg_s2, p_neg_s2, s_neg_s2, flt_s2;
	logic [31:0] g_mag_s2, s_mag_s2;
	logic [MAG_W-1:0] p_mag_s2;
	item_t       item_s3;
	logic [63:0] prod;
	logic [MAG_W-1:0] p_mag, g_ext, y_mag;
	logic        y_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		g_neg_s1 <= gradient[31];
		b_neg_s1 <= coef_old[31];
		s_neg_s1 <= col_scale[31];
		g_mag_s1 <= mag32(gradient);
		b_mag_s1 <= mag32(coef_old);
		s_mag_s1 <= mag32(col_scale);
	end

	always_comb begin
		prod = b_mag_s1 * s_mag_s1;
		p_mag = stdz ? MAG_W'(b_mag_s1) : prod[FRAC_BITS +: MAG_W];
	end

	always_ff @(posedge clk) begin
		g_neg_s2 <= g_neg_s1 && (g_mag_s1 != 32'd0);
		g_mag_s2 <= g_mag_s1;
		p_mag_s2 <= p_mag;
		p_neg_s2 <= (stdz ? b_neg_s1 : (b_neg_s1 != s_neg_s1)) && (p_mag != '0);
		s_neg_s2 <= s_neg_s1;
		s_mag_s2 <= s_mag_s1;
		flt_s2   <= !stdz && (s_mag_s1 == 32'd0);
	end

	// Sign-magnitude sum of gradient and coefficient, scaled unless stdz.
	always_comb begin
		g_ext = MAG_W'(g_mag_s2);
		if (g_neg_s2 == p_neg_s2) begin
			y_mag = g_ext + p_mag_s2;
			y_neg = g_neg_s2;
		end else if (g_ext >= p_mag_s2) begin
			y_mag = g_ext - p_mag_s2;
			y_neg = g_neg_s2;
		end else begin
			y_mag = p_mag_s2 - g_ext;
			y_neg = p_neg_s2;
		end
		if (y_mag == '0) begin
			y_neg = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		item_s3.neg    <= y_neg;
		item_s3.mag    <= y_mag;
		item_s3.s_neg  <= s_neg_s2;
		item_s3.s_mag  <= s_mag_s2;
		item_s3.use_md <= 1'b0;
		item_s3.fault  <= flt_s2;
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

endmodule
`default_nettype wire

### sv/pcu_muldiv.sv
`default_nettype none
module pcu_muldiv (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [pcu_pkg::MAG_W-1:0] a,
	input  wire logic [31:0]               b,
	input  wire logic [31:0]               c,
	output logic                           out_valid,
	output logic [pcu_pkg::MAG_W-1:0]      q
);
	import pcu_pkg::*;

	logic              v_m1, v_m2;
	logic [63:0]       pl_m1;
	logic [HI_W+31:0]  ph_m1;
	logic [31:0]       c_m1, c_m2;
	logic [NUM_W-1:0]  n_m2;

	logic              v_s   [0:MAG_W];
	logic              sat_s [0:MAG_W];
	logic [31:0]       rem_s [0:MAG_W];
	logic [31:0]       div_s [0:MAG_W];
	logic [MAG_W-1:0]  low_s [0:MAG_W];
	logic [MAG_W-1:0]  quo_s [0:MAG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_s[0] <= 1'b0;
		end else begin
			v_m1 <= in_valid;
			v_m2 <= v_m1;
			v_s[0] <= v_m2;
		end
	end

	// Product split into two partial products, summed in the next stage.
	always_ff @(posedge clk) begin
		pl_m1 <= a[31:0] * b;
		ph_m1 <= a[MAG_W-1:32] * b;
		c_m1  <= c;
		n_m2  <= NUM_W'(pl_m1) + (NUM_W'(ph_m1) << 32);
		c_m2  <= c_m1;
	end

	// A quotient too wide for MAG_W bits shows up as a top part not below the divisor.
	always_ff @(posedge clk) begin
		rem_s[0] <= n_m2[NUM_W-1:MAG_W];
		sat_s[0] <= n_m2[NUM_W-1:MAG_W] >= c_m2;
		low_s[0] <= n_m2[MAG_W-1:0];
		quo_s[0] <= '0;
		div_s[0] <= c_m2;
	end

	for (genvar k = 0; k < MAG_W; k++) begin : g_step
		logic [32:0] trial;
		logic        ge;

		always_comb begin
			trial = {rem_s[k], low_s[k][MAG_W-1]};
			ge    = trial >= {1'b0, div_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? 32'(trial - {1'b0, div_s[k]}) : trial[31:0];
			low_s[k+1] <= low_s[k] << 1;
			quo_s[k+1] <= {quo_s[k][MAG_W-2:0], ge};
			sat_s[k+1] <= sat_s[k];
			div_s[k+1] <= div_s[k];
		end
	end

	assign out_valid = v_s[MAG_W];
	assign q = sat_s[MAG_W] ? '1 : quo_s[MAG_W];

endmodule
`default_nettype wire

### sv/pcu_delay.sv
`default_nettype none
module pcu_delay (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire pcu_pkg::item_t  in_item,
	output logic                 out_valid,
	output pcu_pkg::item_t       out_item
);
	import pcu_pkg::*;

	logic  v_s    [0:MD_LAT-1];
	item_t item_s [0:MD_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		item_s[0] <= in_item;
	end

	for (genvar k = 1; k < MD_LAT; k++) begin : g_tap
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			item_s[k] <= item_s[k-1];
		end
	end

	assign out_valid = v_s[MD_LAT-1];
	assign out_item  = item_s[MD_LAT-1];

endmodule
`default_nettype wire

### sv/pcu_band.sv
`default_nettype none
module pcu_band (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire pcu_pkg::item_t            in_item,
	input  wire logic [pcu_pkg::MAG_W-1:0] t2,
	input  wire logic [30:0]               lambda,
	input  wire logic [30:0]               gamma,
	input  wire logic [1:0]                mode,
	output logic                           out_valid,
	output pcu_pkg::item_t                 out_item,
	output logic [pcu_pkg::MAG_W-1:0]      md_a,
	output logic [31:0]                    md_b,
	output logic [31:0]                    md_c
);
	import pcu_pkg::*;

	logic [MAG_W-1:0]           gl_q;
	logic [FRAC_BITS+MAG_W-1:0] gl_prod;
	logic             v_s1;
	item_t            item_s1, nxt;
	logic [MAG_W-1:0] a_s1, a_nxt, y, l_ext, soft_l, soft_t;
	logic [31:0]      b_s1, c_s1, b_nxt, c_nxt, g_ext, gm1, gm2;

	// The knee gamma*lambda depends on configuration only.
	assign gl_prod = gamma * lambda;
	always_ff @(posedge clk) begin
		gl_q <= gl_prod[FRAC_BITS +: MAG_W];
	end

	always_comb begin
		y      = in_item.mag;
		l_ext  = MAG_W'(lambda);
		g_ext  = {1'b0, gamma};
		gm1    = g_ext - ONE_Q;
		gm2    = g_ext - TWO_Q;
		soft_l = (y > l_ext) ? y - l_ext : '0;
		soft_t = (y > t2) ? y - t2 : '0;
		nxt        = in_item;
		nxt.use_md = 1'b0;
		nxt.mag    = soft_l;
		a_nxt      = soft_l;
		b_nxt      = g_ext;
		c_nxt      = gm1;
		case (mode_t'(mode))
			MODE_MCP: begin
				if (g_ext <= ONE_Q) begin
					nxt.fault = 1'b1;
				end else if (y > gl_q) begin
					nxt.mag = y;
				end else begin
					nxt.use_md = 1'b1;
				end
			end
			MODE_SCAD: begin
				if (g_ext <= TWO_Q) begin
					nxt.fault = 1'b1;
				end else if (y > gl_q) begin
					nxt.mag = y;
				end else if (y > MAG_W'({lambda, 1'b0})) begin
					nxt.use_md = 1'b1;
					a_nxt      = soft_t;
					b_nxt      = gm1;
					c_nxt      = gm2;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= nxt;
		a_s1    <= a_nxt;
		b_s1    <= b_nxt;
		c_s1    <= c_nxt;
	end

	assign out_valid = v_s1;
	assign out_item  = item_s1;
	assign md_a      = a_s1;
	assign md_b      = b_s1;
	assign md_c      = c_s1;

endmodule
`default_nettype wire

### sv/penalized_coordinate_update_unit.sv
`default_nettype none
// Penalized coordinate update: one coordinate-descent step with lasso, MCP or
// SCAD thresholding, in signed fixed point with FRAC_BITS fraction bits.
// Input channel: an item is taken on a rising edge where start is high and
// busy is low; gradient, coef_old and col_scale are sampled on that edge.
// Busy is high only in the first cycle after reset, after which the unit
// takes one item every clock cycle without pause.
// Result channel: done is high for exactly one cycle with coef_new and fault,
// once the item has made three passes through a multiply-divide unit of
// MAG_W + 3 stages and six stages of front end, band selection, the
// registered thresholded magnitude and output. The multiply-divide unit
// produces one quotient bit per pipeline stage.
// Results leave in the order items came in; the receiver cannot stall and
// no result is ever held back.
// Configuration: registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. Write them only while
// no item is in flight. Reset clears the pipeline valid bits and loads the
// register defaults: lambda 0, gamma 3.0, lasso, standardised columns.
module penalized_coordinate_update_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] gradient,
	input  wire logic [31:0] coef_old,
	input  wire logic [31:0] col_scale,
	output logic             done,
	output logic [31:0]      coef_new,
	output logic             fault,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import pcu_pkg::*;

	logic        busy_q;
	logic [30:0] lambda_q, gamma_q;
	logic [1:0]  mode_q;
	logic        stdz_q;
	logic        accept;

	logic             fr_valid, t2_valid, dl_valid, bd_valid, bm_valid, bi_valid;
	logic             fm_valid, fi_valid, r_valid_s;
	item_t            fr_item, dl_item, bd_item, bi_item, fi_item, r_item_s, r_item_nxt;
	logic [MAG_W-1:0] t2_q, md_a, bm_q, fm_q;
	logic [31:0]      md_b, md_c;

	logic             done_q, fault_q;
	logic [31:0]      coef_new_q, res;
	logic [MAG_W-1:0] fin;
	logic             fin_neg;

	// Busy only holds off the first cycle after reset is released.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign accept    = start && !busy_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= '0;
			gamma_q  <= 31'd196608;
			mode_q   <= MODE_LASSO;
			stdz_q   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_LAMBDA: lambda_q <= cfg_data[30:0];
				REG_GAMMA:  gamma_q  <= cfg_data[30:0];
				REG_MODE:   mode_q   <= cfg_data[1:0];
				REG_STDZ:   stdz_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Front end: sign and magnitude, scaling of the coefficient, the sum y.
	pcu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.gradient  (gradient),
		.coef_old  (coef_old),
		.col_scale (col_scale),
		.stdz      (stdz_q),
		.out_valid (fr_valid),
		.out_item  (fr_item)
	);

	// The SCAD inner threshold lambda*gamma/(gamma-1) is formed for every item
	// while the item waits beside it in a matching delay line.
	pcu_muldiv u_md_t2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.a         (MAG_W'(lambda_q)),
		.b         ({1'b0, gamma_q}),
		.c         ({1'b0, gamma_q} - ONE_Q),
		.out_valid (t2_valid),
		.q         (t2_q)
	);

	pcu_delay u_dly_t2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_item   (fr_item),
		.out_valid (dl_valid),
		.out_item  (dl_item)
	);

	// Band selection picks a direct result or the operands of the band scaling.
	pcu_band u_band (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dl_valid && t2_valid),
		.in_item   (dl_item),
		.t2        (t2_q),
		.lambda    (lambda_q),
		.gamma     (gamma_q),
		.mode      (mode_q),
		.out_valid (bd_valid),
		.out_item  (bd_item),
		.md_a      (md_a),
		.md_b      (md_b),
		.md_c      (md_c)
	);

	pcu_muldiv u_md_band (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bd_valid),
		.a         (md_a),
		.b         (md_b),
		.c         (md_c),
		.out_valid (bm_valid),
		.q         (bm_q)
	);

	pcu_delay u_dly_band (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bd_valid),
		.in_item   (bd_item),
		.out_valid (bi_valid),
		.out_item  (bi_item)
	);

	// The thresholded magnitude is registered before the division by the scale.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_valid_s <= 1'b0;
		end else begin
			r_valid_s <= bi_valid && bm_valid;
		end
	end

	always_comb begin
		r_item_nxt = bi_item;
		if (bi_item.use_md) begin
			r_item_nxt.mag = bm_q;
		end
	end

	always_ff @(posedge clk) begin
		r_item_s <= r_item_nxt;
	end

	// In unstandardised mode the result is divided by the column scale; in
	// standardised mode the quotient is ignored at the output.
	pcu_muldiv u_md_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (r_valid_s),
		.a         (r_item_s.mag),
		.b         (ONE_Q),
		.c         (r_item_s.s_mag),
		.out_valid (fm_valid),
		.q         (fm_q)
	);

	pcu_delay u_dly_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (r_valid_s),
		.in_item   (r_item_s),
		.out_valid (fi_valid),
		.out_item  (fi_item)
	);

	// Sign, saturation to 32 bits, and the fault override.
	always_comb begin
		fin     = stdz_q ? fi_item.mag : fm_q;
		fin_neg = stdz_q ? fi_item.neg : (fi_item.neg != fi_item.s_neg);
		if (fin == '0) begin
			fin_neg = 1'b0;
		end
		if (fi_item.fault) begin
			res = '0;
		end else if (fin_neg) begin
			res = (fin > MAG_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
				: (~fin[31:0] + 32'd1);
		end else begin
			res = (fin > MAG_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : fin[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fi_valid && fm_valid;
		end
	end

	always_ff @(posedge clk) begin
		coef_new_q <= res;
		fault_q    <= fi_item.fault;
	end

	assign done     = done_q;
	assign coef_new = coef_new_q;
	assign fault    = fault_q;

endmodule
`default_nettype wire

### sv/pcu_checker.sv
`default_nettype none
`include "assert_macros.svh"
module pcu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        fault,
	input wire logic [31:0] coef_new,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready
);
	import pcu_pkg::*;

	// Once the unit is free after reset it stays free.
	`PCU_ASSERT_NEXT(a_busy_stays_low, clk, arst_n, !busy, !busy)

	// Every result follows an accepted item by the fixed latency.
	`PCU_ASSERT(a_done_latency, clk, arst_n, !done || $past(start && !busy, LATENCY))

	// A faulted result carries a zero coefficient.
	`PCU_ASSERT(a_fault_zero, clk, arst_n, !(done && fault) || (coef_new == 32'd0))

	// Configuration writes are never held off.
	`PCU_ASSERT(a_cfg_ready, clk, arst_n, !cfg_valid || cfg_ready)

endmodule

bind penalized_coordinate_update_unit pcu_checker u_pcu_checker (.*);
`default_nettype wire
